// ===== sv/rrts_pkg.sv =====
// Shared types and constants for the rated record table sorter.
// No dependencies; imported by the top level.
`default_nettype none

package rrts_pkg;

  // Field widths of one record
  localparam int unsigned IdW     = 16;
  localparam int unsigned YearW   = 12;
  localparam int unsigned RatingW = 7;

  // Highest rating in tenths of a point
  localparam logic [RatingW-1:0] RatingMax = 7'd100;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  // Status codes of a result beat
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_EMPTY     = 3'd3,
    STATUS_EXHAUSTED = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_REM_SCAN,
    ST_REM_DONE,
    ST_SORT_PASS,
    ST_SORT_TAIL,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_LIST_EMPTY
  } state_e;

  // One stored record
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [YearW-1:0]   year;
    logic [RatingW-1:0] rating;
  } rec_t;

  // Input beat
  typedef struct packed {
    logic [1:0]         cmd;
    logic [YearW-1:0]   new_year;
    logic [RatingW-1:0] new_rating;
    logic [IdW-1:0]     target_id;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0]         status;
    logic [IdW-1:0]     rec_id;
    logic [YearW-1:0]   rec_year;
    logic [RatingW-1:0] rec_rating;
    logic               last;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/rated_record_table_sorter.sv =====
// Top level of the rated record table sorter: command sequencer, table RAM, result register.
// Depends on rrts_pkg and rrts_ram.
`default_nettype none

// Keeps up to CAPACITY records (id, year, rating in tenths) in one RAM and
// runs one command at a time; in_stall_o stays high until the command has
// finished. Remove streams the table once through the RAM read port, shifting
// entries down behind the match. List bubble-sorts the table in place with
// one rating comparator and one RAM read and one write per cycle, then emits
// each record by a RAM read followed by a load into the result register,
// which waits while the output is stalled. The table needs no clearing after
// reset; only entries below the record count are read.
module rated_record_table_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rrts_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rrts_pkg::out_beat_t    out_data_o
);

  import rrts_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IdW-1:0]   next_id_q, next_id_d;
  in_beat_t         cmd_q, cmd_d;
  logic [CW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]    lim_q, lim_d;
  logic             dv_q, dv_d;
  logic [AW-1:0]    di_q, di_d;
  logic             found_q, found_d;
  rec_t             carry_q, carry_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;
  logic             out_load;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  rec_t             ram_wdata, ram_rdata;

  logic             out_free;
  logic             issue;
  logic             stream_done;
  logic             emit_last;
  logic             cmp_lt;
  logic             id_eq;
  logic [RatingW-1:0] sat_rating;

  rrts_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Shared compare unit and stream bookkeeping
  assign cmp_lt      = carry_q.rating < ram_rdata.rating;
  assign id_eq       = ram_rdata.id == cmd_q.target_id;
  assign issue       = rd_cnt_q < lim_q;
  assign stream_done = !issue && !dv_q;
  assign emit_last   = rd_cnt_q == (count_q - CW'(1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sat_rating  = (cmd_q.new_rating > RatingMax) ? RatingMax : cmd_q.new_rating;

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.cmd)
            CMD_ADD:    state_d = ST_ADD;
            CMD_REMOVE: state_d = (count_q == '0) ? ST_REM_DONE : ST_REM_SCAN;
            CMD_LIST: begin
              if (count_q == '0) begin
                state_d = ST_LIST_EMPTY;
              end else if (count_q == CW'(1)) begin
                state_d = ST_EMIT_RD;
              end else begin
                state_d = ST_SORT_PASS;
              end
            end
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:        if (out_free) state_d = ST_IDLE;
      ST_REM_SCAN:   if (stream_done) state_d = ST_REM_DONE;
      ST_REM_DONE:   if (out_free) state_d = ST_IDLE;
      ST_SORT_PASS:  if (stream_done) state_d = ST_SORT_TAIL;
      ST_SORT_TAIL:  state_d = (lim_q > CW'(2)) ? ST_SORT_PASS : ST_EMIT_RD;
      ST_EMIT_RD:    state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_LIST_EMPTY: if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result beats
  always_comb begin
    count_d   = count_q;
    next_id_d = next_id_q;
    cmd_d     = cmd_q;
    rd_cnt_d  = rd_cnt_q;
    lim_d     = lim_q;
    dv_d      = 1'b0;
    di_d      = di_q;
    found_d   = found_q;
    carry_d   = carry_q;
    out_load  = 1'b0;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = carry_q;
    ram_re    = 1'b0;
    ram_raddr = rd_cnt_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        // Latch the command and arm the read stream
        if (in_valid_i) begin
          cmd_d    = in_data_i;
          rd_cnt_d = '0;
          lim_d    = count_q;
          found_d  = 1'b0;
        end
      end

      ST_ADD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{status: STATUS_OK, rec_id: '0, rec_year: '0, rec_rating: '0,
                       last: 1'b1};
          if (count_q == CW'(CAPACITY)) begin
            out_d.status = STATUS_FULL;
          end else if (next_id_q == '0) begin
            out_d.status = STATUS_EXHAUSTED;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = count_q[AW-1:0];
            ram_wdata        = '{id: next_id_q, year: cmd_q.new_year, rating: sat_rating};
            count_d          = count_q + CW'(1);
            next_id_d        = next_id_q + IdW'(1);
            out_d.rec_id     = next_id_q;
            out_d.rec_year   = cmd_q.new_year;
            out_d.rec_rating = sat_rating;
          end
        end
      end

      ST_REM_SCAN: begin
        // Read ahead; once matched, move every later entry down by one
        if (issue) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + CW'(1);
          dv_d     = 1'b1;
          di_d     = rd_cnt_q[AW-1:0];
        end
        if (dv_q) begin
          if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = di_q - AW'(1);
            ram_wdata = ram_rdata;
          end else if (id_eq) begin
            found_d = 1'b1;
          end
        end
      end

      ST_REM_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{status: found_q ? STATUS_OK : STATUS_NOT_FOUND,
                       rec_id: cmd_q.target_id, rec_year: '0, rec_rating: '0,
                       last: 1'b1};
          if (found_q) count_d = count_q - CW'(1);
        end
      end

      ST_SORT_PASS: begin
        // Carry the lower-rated record rightwards; write the other one back
        if (issue) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + CW'(1);
          dv_d     = 1'b1;
          di_d     = rd_cnt_q[AW-1:0];
        end
        if (dv_q) begin
          if (di_q == '0) begin
            carry_d = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = di_q - AW'(1);
            if (cmp_lt) begin
              ram_wdata = ram_rdata;
            end else begin
              ram_wdata = carry_q;
              carry_d   = ram_rdata;
            end
          end
        end
      end

      ST_SORT_TAIL: begin
        // Drop the carried record into the last place of the pass
        ram_we    = 1'b1;
        ram_waddr = AW'(lim_q - CW'(1));
        ram_wdata = carry_q;
        lim_d     = lim_q - CW'(1);
        rd_cnt_d  = '0;
      end

      ST_EMIT_RD: begin
        ram_re = 1'b1;
      end

      ST_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{status: STATUS_OK, rec_id: ram_rdata.id, rec_year: ram_rdata.year,
                       rec_rating: ram_rdata.rating, last: emit_last};
          rd_cnt_d = rd_cnt_q + CW'(1);
        end
      end

      ST_LIST_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{status: STATUS_EMPTY, rec_id: '0, rec_year: '0, rec_rating: '0,
                       last: 1'b1};
        end
      end

      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Result register valid: set on load, clear once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      next_id_q   <= IdW'(1);
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_id_q   <= next_id_d;
      dv_q        <= dv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and pointers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rd_cnt_q <= rd_cnt_d;
    lim_q    <= lim_d;
    di_q     <= di_d;
    carry_q  <= carry_d;
    out_q    <= out_d;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_ids_stay_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q == '0 |=> next_id_q == '0)
    else $error("id counter left the exhausted state");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("table read and write hit the same entry");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_ADD || state_q == ST_REM_SCAN ||
                state_q == ST_SORT_PASS || state_q == ST_SORT_TAIL))
    else $error("table written outside add, remove or sort");

  a_sort_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SORT_PASS |-> lim_q >= CW'(2) && lim_q <= count_q)
    else $error("sort pass span out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/rrts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rrts_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_rated_record_table_sorter.sv =====
// Testbench for rated_record_table_sorter: drives add, remove and list command beats,
// predicts every reply beat from a shadow copy of the record table and checks them in order.
// Depends on rrts_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_rated_record_table_sorter;
  import rrts_pkg::*;

  localparam int unsigned Capacity     = 64;
  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned DrainCycles  = 60;
  localparam int unsigned RandomItems  = 30;
  localparam int unsigned HoldCycles   = 3000;
  localparam int unsigned IdlePercent  = 23;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // Shadow of the block's table, next id and pending replies
  rec_t           shadow_tbl [Capacity];
  int unsigned    shadow_count   = 0;
  logic [IdW-1:0] shadow_next_id = 16'd1;
  out_beat_t      expected_replies [$];

  bit          src_idle_en = 1'b0;
  bit          snk_idle_en = 1'b0;
  int unsigned hold_req    = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned beats_sent  = 0;
  int unsigned replies_checked = 0;

  rated_record_table_sorter #(
    .CAPACITY (Capacity)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d replies still pending",
               cycle_count, expected_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic out_beat_t make_reply(status_e st, logic [IdW-1:0] id,
                                           logic [YearW-1:0] yr,
                                           logic [RatingW-1:0] rt, logic lst);
    out_beat_t r;
    r.status     = st;
    r.rec_id     = id;
    r.rec_year   = yr;
    r.rec_rating = rt;
    r.last       = lst;
    return r;
  endfunction

  // Apply one accepted command to the shadow table and queue its replies
  function automatic void predict_table_reply(in_beat_t b);
    rec_t               moved;
    logic [RatingW-1:0] rt;
    bit                 found;
    int unsigned        i, j;
    case (b.cmd)
      CMD_ADD: begin
        if (shadow_count >= Capacity) begin
          expected_replies.push_back(make_reply(STATUS_FULL, '0, '0, '0, 1'b1));
        end else if (shadow_next_id == '0) begin
          expected_replies.push_back(make_reply(STATUS_EXHAUSTED, '0, '0, '0, 1'b1));
        end else begin
          rt = (b.new_rating > RatingMax) ? RatingMax : b.new_rating;
          shadow_tbl[shadow_count].id     = shadow_next_id;
          shadow_tbl[shadow_count].year   = b.new_year;
          shadow_tbl[shadow_count].rating = rt;
          shadow_count++;
          expected_replies.push_back(make_reply(STATUS_OK, shadow_next_id, b.new_year,
                                                rt, 1'b1));
          shadow_next_id = shadow_next_id + 1'b1;
        end
      end
      CMD_REMOVE: begin
        found = 1'b0;
        for (i = 0; i < shadow_count && !found; i++) begin
          if (shadow_tbl[i].id == b.target_id) begin
            for (j = i; j + 1 < shadow_count; j++) shadow_tbl[j] = shadow_tbl[j + 1];
            shadow_count--;
            found = 1'b1;
          end
        end
        if (found) begin
          expected_replies.push_back(make_reply(STATUS_OK, b.target_id, '0, '0, 1'b1));
        end else begin
          expected_replies.push_back(make_reply(STATUS_NOT_FOUND, b.target_id, '0, '0,
                                                1'b1));
        end
      end
      CMD_LIST: begin
        if (shadow_count == 0) begin
          expected_replies.push_back(make_reply(STATUS_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          // Stable bubble sort, descending by rating
          for (i = 0; i + 1 < shadow_count; i++) begin
            for (j = 0; j + 1 < shadow_count - i; j++) begin
              if (shadow_tbl[j].rating < shadow_tbl[j + 1].rating) begin
                moved             = shadow_tbl[j];
                shadow_tbl[j]     = shadow_tbl[j + 1];
                shadow_tbl[j + 1] = moved;
              end
            end
          end
          for (i = 0; i < shadow_count; i++) begin
            expected_replies.push_back(make_reply(STATUS_OK, shadow_tbl[i].id,
                                                  shadow_tbl[i].year, shadow_tbl[i].rating,
                                                  i + 1 == shadow_count));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one reply beat against the oldest pending expectation
  function automatic void check_reply(out_beat_t got);
    out_beat_t want;
    replies_checked++;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected reply: st=%0d id=%0d yr=%0d rt=%0d last=%0d",
                 got.status, got.rec_id, got.rec_year, got.rec_rating, got.last);
      return;
    end
    want = expected_replies.pop_front();
    if (got.status !== want.status || got.rec_id !== want.rec_id ||
        got.rec_year !== want.rec_year || got.rec_rating !== want.rec_rating ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("reply %0d: expected st=%0d id=%0d yr=%0d rt=%0d last=%0d",
                 replies_checked, want.status, want.rec_id, want.rec_year,
                 want.rec_rating, want.last);
        $display("  got st=%0d id=%0d yr=%0d rt=%0d last=%0d",
                 got.status, got.rec_id, got.rec_year, got.rec_rating, got.last);
      end
    end
  endfunction

  // Check accepted reply beats, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reply(out_data);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (snk_idle_en && $urandom_range(99) < IdlePercent) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one command beat, hold it until accepted, then predict it
  task automatic send_beat(input in_beat_t b);
    if (src_idle_en) begin
      while ($urandom_range(99) < IdlePercent) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table_reply(b);
    beats_sent++;
  endtask

  function automatic in_beat_t make_beat(logic [1:0] cmd, logic [YearW-1:0] yr,
                                         logic [RatingW-1:0] rt, logic [IdW-1:0] id);
    in_beat_t b;
    b.cmd        = cmd;
    b.new_year   = yr;
    b.new_rating = rt;
    b.target_id  = id;
    return b;
  endfunction

  // Unused fields of each command carry random noise
  task automatic send_add(input logic [YearW-1:0] yr, input logic [RatingW-1:0] rt);
    send_beat(make_beat(CMD_ADD, yr, rt, IdW'($urandom_range(16'hFFFF))));
  endtask

  task automatic send_remove(input logic [IdW-1:0] id);
    send_beat(make_beat(CMD_REMOVE, YearW'($urandom_range(12'hFFF)),
                        RatingW'($urandom_range(127)), id));
  endtask

  task automatic send_list();
    send_beat(make_beat(CMD_LIST, YearW'($urandom_range(12'hFFF)),
                        RatingW'($urandom_range(127)), IdW'($urandom_range(16'hFFFF))));
  endtask

  task automatic send_unused();
    send_beat(make_beat(CmdUnused, YearW'($urandom_range(12'hFFF)),
                        RatingW'($urandom_range(127)), IdW'($urandom_range(16'hFFFF))));
  endtask

  // Ratings bunched so that ties and saturation turn up often
  function automatic logic [RatingW-1:0] rand_rating();
    case ($urandom_range(3))
      0:       return RatingW'($urandom_range(127));
      1:       return RatingW'($urandom_range(2) * 50);
      2:       return RatingW'($urandom_range(10));
      default: return RatingW'($urandom_range(100, 90));
    endcase
  endfunction

  function automatic logic [YearW-1:0] rand_year();
    return YearW'($urandom_range(12'hFFF));
  endfunction

  // Drop valid and wait for every pending reply, then let the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Field extremes, saturation, ties, empty table and the unused command
  task automatic test_directed();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_list();
    send_remove(16'd5);
    send_unused();
    send_add(12'd0, 7'd0);
    send_add(12'hFFF, 7'd100);
    send_add(12'd1234, 7'd127);
    send_add(12'd2000, 7'd101);
    send_add(12'd1999, 7'd50);
    send_add(12'd2001, 7'd50);
    send_add(12'd7, 7'd100);
    send_list();
    send_remove(16'd1);
    send_remove(16'hFFFF);
    send_remove(16'd0);
    send_remove(shadow_next_id - 1'b1);
    send_list();
    send_beat(make_beat(CmdUnused, '1, '1, '1));
    send_add(12'h800, 7'd64);
    send_add(12'h555, 7'd50);
    send_list();
    wait_drain();
  endtask

  // Mixed traffic; idling stays off for the first stretch
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < RandomItems) begin
      src_idle_en = (sent >= 10);
      snk_idle_en = (sent >= 10);
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_unused();
      end else begin
        if (pick < 50 && shadow_count < 48) begin
          send_add(rand_year(), rand_rating());
        end else if (pick < 75 && shadow_count != 0) begin
          send_remove(shadow_tbl[$urandom_range(shadow_count - 1)].id);
        end else if (pick < 84) begin
          send_remove(IdW'($urandom_range(16'hFFFF)));
        end else begin
          send_list();
        end
        sent++;
      end
    end
    wait_drain();
  endtask

  // Fill the table back to back, add past capacity, then hold the output off during a list
  task automatic test_full_table();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    while (shadow_count < Capacity) send_add(rand_year(), rand_rating());
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_add(12'hFFF, 7'd127);
    send_add(rand_year(), rand_rating());
    hold_req = HoldCycles;
    send_list();
    send_remove(shadow_tbl[0].id);
    send_remove(shadow_tbl[shadow_count - 1].id);
    send_remove(shadow_tbl[shadow_count / 2].id);
    send_list();
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_full_table();
    if (expected_replies.size() != 0) mismatches++;
    $display("checked %0d reply beats from %0d command beats in %0d cycles",
             replies_checked, beats_sent, cycle_count);
    $display("covered empty and full tables, ties, saturation and a long output hold-off");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching reply beats", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
